### rtl/hbwd_pkg.sv
// ----------------------------------------------------------------------------
// Hard-brake window detector package
// Shared types, register indexes and status codes for the detector.
// ----------------------------------------------------------------------------
package hbwd_pkg;

    localparam int SPEED_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Register values after reset.
    localparam logic             ENABLE_RST      = 1'b1;
    localparam logic [CFG_W-1:0] NOISE_LIMIT_RST = 16'd256;
    localparam int               BRAKE_DROP_RST  = 512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE      = 2'd0,
        CFG_NOISE_LIMIT = 2'd1,
        CFG_BRAKE_DROP  = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_BRAKE = 2'd1,
        ST_NOISE = 2'd2,
        ST_OFF   = 2'd3
    } status_t;

    // Item held between the window update and the result register.
    typedef struct packed {
        logic    valid;
        status_t code;
        logic    full;
    } stage_t;

endpackage

### rtl/hbwd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Hard-brake window detector configuration registers
// Holds enable and noise limit, and keeps the braking threshold premultiplied.
// ----------------------------------------------------------------------------
module hbwd_cfg_regs #(
    parameter int WINDOW = 8,
    parameter int TH_W   = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hbwd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hbwd_pkg::CFG_W-1:0]          cfg_data,
    output logic                                enable,
    output logic [hbwd_pkg::CFG_W-1:0]          noise_limit,
    output logic [TH_W-1:0]                     brake_thresh
);

    logic                       enable_reg;
    logic                       enable_next;
    logic [hbwd_pkg::CFG_W-1:0] noise_limit_reg;
    logic [hbwd_pkg::CFG_W-1:0] noise_limit_next;
    logic [TH_W-1:0]            thresh_reg;
    logic [TH_W-1:0]            thresh_next;

    assign cfg_ready = 1'b1;

    // The threshold is brake_drop times the window length, formed once per write.
    always_comb
    begin
        enable_next      = enable_reg;
        noise_limit_next = noise_limit_reg;
        thresh_next      = thresh_reg;
        if (cfg_valid)
        begin
            case (hbwd_pkg::cfg_reg_t'(cfg_index))
                hbwd_pkg::CFG_ENABLE:      enable_next = cfg_data[0];
                hbwd_pkg::CFG_NOISE_LIMIT: noise_limit_next = cfg_data;
                hbwd_pkg::CFG_BRAKE_DROP:
                    thresh_next = TH_W'(cfg_data) * TH_W'(WINDOW);
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= hbwd_pkg::ENABLE_RST;
            noise_limit_reg <= hbwd_pkg::NOISE_LIMIT_RST;
            thresh_reg      <= TH_W'(hbwd_pkg::BRAKE_DROP_RST * WINDOW);
        end
        else
        begin
            enable_reg      <= enable_next;
            noise_limit_reg <= noise_limit_next;
            thresh_reg      <= thresh_next;
        end
    end

    assign enable       = enable_reg;
    assign noise_limit  = noise_limit_reg;
    assign brake_thresh = thresh_reg;

endmodule

### rtl/hbwd_window.sv
// ----------------------------------------------------------------------------
// Hard-brake window detector sample line
// Noise check, delay line of two windows and their running sums.
// ----------------------------------------------------------------------------
module hbwd_window #(
    parameter int WINDOW = 8,
    parameter int SUM_W  = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  take,
    input  logic                                  advance,
    input  logic signed [hbwd_pkg::SPEED_W-1:0]   speed,
    input  logic                                  enable,
    input  logic [hbwd_pkg::CFG_W-1:0]            noise_limit,
    output hbwd_pkg::stage_t                      stage,
    output logic signed [SUM_W-1:0]               recent_sum,
    output logic signed [SUM_W-1:0]               older_sum
);

    localparam int LINE_LEN = 2 * WINDOW;
    localparam int FILL_W   = $clog2(LINE_LEN + 1);
    localparam int JUMP_W   = hbwd_pkg::SPEED_W + 1;

    logic signed [hbwd_pkg::SPEED_W-1:0] line_reg [LINE_LEN];
    logic [FILL_W-1:0]                   fill_reg;
    logic [FILL_W-1:0]                   fill_next;
    logic signed [SUM_W-1:0]             recent_reg;
    logic signed [SUM_W-1:0]             recent_next;
    logic signed [SUM_W-1:0]             older_reg;
    logic signed [SUM_W-1:0]             older_next;
    hbwd_pkg::stage_t                    stage_reg;
    hbwd_pkg::stage_t                    stage_next;

    logic signed [JUMP_W-1:0]            jump;
    logic [JUMP_W-1:0]                   jump_mag;
    logic                                noisy;
    logic                                store;
    logic signed [hbwd_pkg::SPEED_W-1:0] mid_val;
    logic signed [hbwd_pkg::SPEED_W-1:0] old_val;

    // Entry 0 is the newest sample; it is zero until the first sample is
    // stored, which gives the reference of zero for the very first check.
    assign mid_val = line_reg[WINDOW-1];
    assign old_val = line_reg[LINE_LEN-1];

    always_comb
    begin
        jump     = JUMP_W'(line_reg[0]) - JUMP_W'(speed);
        jump_mag = jump[JUMP_W-1] ? JUMP_W'(-jump) : JUMP_W'(jump);
        noisy    = jump_mag > JUMP_W'(noise_limit);
        store    = take && enable && !noisy;

        recent_next = recent_reg;
        older_next  = older_reg;
        fill_next   = fill_reg;
        if (store)
        begin
            recent_next = recent_reg + SUM_W'(speed) - SUM_W'(mid_val);
            older_next  = older_reg + SUM_W'(mid_val) - SUM_W'(old_val);
            if (fill_reg != FILL_W'(LINE_LEN))
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end

        stage_next = stage_reg;
        if (take)
        begin
            stage_next.valid = 1'b1;
            stage_next.full  = (fill_next == FILL_W'(LINE_LEN));
            if (!enable)
            begin
                stage_next.code = hbwd_pkg::ST_OFF;
            end
            else if (noisy)
            begin
                stage_next.code = hbwd_pkg::ST_NOISE;
            end
            else
            begin
                stage_next.code = hbwd_pkg::ST_CLEAR;
            end
        end
        else if (advance)
        begin
            stage_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINE_LEN; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (store)
        begin
            line_reg[0] <= speed;
            for (int i = 1; i < LINE_LEN; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            recent_reg <= '0;
            older_reg  <= '0;
            stage_reg  <= '{valid: 1'b0, code: hbwd_pkg::ST_CLEAR, full: 1'b0};
        end
        else
        begin
            fill_reg   <= fill_next;
            recent_reg <= recent_next;
            older_reg  <= older_next;
            stage_reg  <= stage_next;
        end
    end

    assign stage      = stage_reg;
    assign recent_sum = recent_reg;
    assign older_sum  = older_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(LINE_LEN))
        else $error("fill count beyond line length");

    a_off_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !enable) |=> ($stable(recent_reg) && $stable(older_reg)
                               && $stable(fill_reg)))
        else $error("disabled sample changed window state");

    a_noise_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (take && enable && noisy) |=> ($stable(recent_reg) && $stable(fill_reg)
                                       && stage_reg.code == hbwd_pkg::ST_NOISE))
        else $error("rejected sample changed window state");

    a_empty_sums_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> (recent_reg == '0 && older_reg == '0))
        else $error("sums non-zero with empty line");
`endif

endmodule

### rtl/hbwd_result.sv
// ----------------------------------------------------------------------------
// Hard-brake window detector result stage
// Compares the window drop with the threshold and holds the status register.
// ----------------------------------------------------------------------------
module hbwd_result #(
    parameter int SUM_W = 20,
    parameter int TH_W  = 20
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hbwd_pkg::stage_t         stage,
    input  logic signed [SUM_W-1:0]  recent_sum,
    input  logic signed [SUM_W-1:0]  older_sum,
    input  logic [TH_W-1:0]          brake_thresh,
    input  logic                     out_stall,
    output logic                     advance,
    output logic                     out_valid,
    output logic [1:0]               status
);

    localparam int CMP_W = ((SUM_W + 1) > (TH_W + 1)) ? (SUM_W + 1) : (TH_W + 1);

    logic                    valid_reg;
    logic                    valid_next;
    hbwd_pkg::status_t       status_reg;
    hbwd_pkg::status_t       status_next;
    logic signed [CMP_W-1:0] drop;
    logic signed [CMP_W-1:0] thresh_s;

    assign advance = !valid_reg || !out_stall;

    always_comb
    begin
        drop     = CMP_W'(older_sum) - CMP_W'(recent_sum);
        thresh_s = CMP_W'(brake_thresh);
        status_next = stage.code;
        if (stage.code == hbwd_pkg::ST_CLEAR && stage.full && (drop > thresh_s))
        begin
            status_next = hbwd_pkg::ST_BRAKE;
        end
        valid_next = advance ? stage.valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
        end
    end

    assign out_valid = valid_reg;
    assign status    = status_reg;

endmodule

### rtl/hard_brake_window_detector.sv
// ----------------------------------------------------------------------------
// Hard-brake window detector
// Flags hard braking from the drop between two moving windows of speed.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_stall    speed (signed 16 bits, 1/256 m/s)
//   output    out_valid / out_stall  status (2 bits)
//   config    cfg_valid / cfg_ready  cfg_index (2 bits), cfg_data (16 bits)
//
// One sample can be taken every cycle while the input is not stalled. The
// delay line and sums update at the transfer edge of a stored sample, the
// threshold compare runs in the following cycle, and the status register is
// loaded from it when the result stage advances. Reset clears the delay line,
// sums and fill count and restores the registers. A stalled output holds its
// result; input is stalled only when both stages hold results.
// ----------------------------------------------------------------------------
module hard_brake_window_detector #(
    parameter int WINDOW = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [hbwd_pkg::SPEED_W-1:0]  speed,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           status,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hbwd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hbwd_pkg::CFG_W-1:0]           cfg_data
);

    localparam int SUM_W = hbwd_pkg::SPEED_W + 1 + $clog2(WINDOW);
    localparam int TH_W  = hbwd_pkg::CFG_W + 1 + $clog2(WINDOW);

    logic                       enable;
    logic [hbwd_pkg::CFG_W-1:0] noise_limit;
    logic [TH_W-1:0]            brake_thresh;
    logic                       take;
    logic                       advance;
    hbwd_pkg::stage_t           stage;
    logic signed [SUM_W-1:0]    recent_sum;
    logic signed [SUM_W-1:0]    older_sum;

    assign in_stall = stage.valid && !advance;
    assign take     = in_valid && !in_stall;

    hbwd_cfg_regs #(
        .WINDOW (WINDOW),
        .TH_W   (TH_W)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .enable       (enable),
        .noise_limit  (noise_limit),
        .brake_thresh (brake_thresh)
    );

    hbwd_window #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .advance     (advance),
        .speed       (speed),
        .enable      (enable),
        .noise_limit (noise_limit),
        .stage       (stage),
        .recent_sum  (recent_sum),
        .older_sum   (older_sum)
    );

    hbwd_result #(
        .SUM_W (SUM_W),
        .TH_W  (TH_W)
    ) u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .recent_sum   (recent_sum),
        .older_sum    (older_sum),
        .brake_thresh (brake_thresh),
        .out_stall    (out_stall),
        .advance      (advance),
        .out_valid    (out_valid),
        .status       (status)
    );

`ifndef NO_ASSERTIONS
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && stage.valid))
        else $error("input stalled with room in the pipeline");

    a_item_reaches_stage: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> stage.valid)
        else $error("transferred sample missing from window stage");

    a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (stage.valid && advance) |=> out_valid)
        else $error("window stage result lost");
`endif

endmodule
